>>> rtl/pcar_pkg.sv
// ----------------------------------------------------------------------------
// pcar_pkg
// Shared widths, register indexes and constants for the config address router.
// ----------------------------------------------------------------------------
package pcar_pkg;

  // request fields
  localparam int KIND_W = 1;
  localparam int BUS_W  = 8;
  localparam int DEV_W  = 8;
  localparam int FN_W   = 8;
  localparam int OFF_W  = 13;
  localparam int DATA_W = 32;

  // result fields
  localparam int ADDR_W = 64;
  localparam int CNT_W  = 32;

  // configuration port
  localparam int CFG_INDEX_W    = 3;
  localparam int CFG_DATA_W     = 64;
  localparam int REGION_COUNT_W = 2;

  // register file holds at most this many region descriptors
  localparam int CFG_REGIONS          = 2;
  localparam int REGION_SLOTS_DEFAULT = 2;
  localparam int CFG_REGION_STRIDE    = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_REGION_COUNT      = 3'd0,
    CFG_REGION0_BASE      = 3'd1,
    CFG_REGION0_FIRST_BUS = 3'd2,
    CFG_REGION0_LAST_BUS  = 3'd3,
    CFG_REGION1_BASE      = 3'd4,
    CFG_REGION1_FIRST_BUS = 3'd5,
    CFG_REGION1_LAST_BUS  = 3'd6
  } cfg_index_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_READ  = 1'b0,
    KIND_WRITE = 1'b1
  } req_kind_e;

  // ecam window layout
  localparam int ECAM_DEV_LIMIT = 32;
  localparam int ECAM_FN_LIMIT  = 8;
  localparam int ECAM_OFF_LIMIT = 4096;
  localparam int ECAM_DEV_W     = 5;
  localparam int ECAM_FN_W      = 3;
  localparam int ECAM_OFF_W     = 12;
  localparam int ECAM_OFFSET_W  = BUS_W + ECAM_DEV_W + ECAM_FN_W + ECAM_OFF_W;

  // legacy port address word
  localparam logic [31:0] LEGACY_ENABLE   = 32'h8000_0000;
  localparam logic [7:0]  LEGACY_REG_MASK = 8'hfc;
  localparam int          LEGACY_BUS_SH   = 16;
  localparam int          LEGACY_DEV_SH   = 11;
  localparam int          LEGACY_FN_SH    = 8;

endpackage

>>> rtl/pcar_req_if.sv
// ----------------------------------------------------------------------------
// pcar_req_if
// Request channel: one config read or write transaction per handshake.
// ----------------------------------------------------------------------------
interface pcar_req_if import pcar_pkg::*; ();

  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [BUS_W-1:0]  bus_number;
  logic [DEV_W-1:0]  device_number;
  logic [FN_W-1:0]   function_number;
  logic [OFF_W-1:0]  register_offset;
  logic [DATA_W-1:0] write_data;

  modport source (
    output valid, kind, bus_number, device_number, function_number,
           register_offset, write_data,
    input  ready
  );

  modport sink (
    input  valid, kind, bus_number, device_number, function_number,
           register_offset, write_data,
    output ready
  );

endinterface

>>> rtl/pcar_rsp_if.sv
// ----------------------------------------------------------------------------
// pcar_rsp_if
// Result channel: routed address, store data and access counters.
// ----------------------------------------------------------------------------
interface pcar_rsp_if import pcar_pkg::*; ();

  logic              valid;
  logic              ready;
  logic              via_ecam;
  logic [ADDR_W-1:0] target_address;
  logic              fell_back;
  logic [DATA_W-1:0] store_data;
  logic [CNT_W-1:0]  ecam_read_total;
  logic [CNT_W-1:0]  legacy_read_total;
  logic [CNT_W-1:0]  read_fallback_total;
  logic [CNT_W-1:0]  ecam_write_total;
  logic [CNT_W-1:0]  legacy_write_total;
  logic [CNT_W-1:0]  write_fallback_total;

  modport source (
    output valid, via_ecam, target_address, fell_back, store_data,
           ecam_read_total, legacy_read_total, read_fallback_total,
           ecam_write_total, legacy_write_total, write_fallback_total,
    input  ready
  );

  modport sink (
    input  valid, via_ecam, target_address, fell_back, store_data,
           ecam_read_total, legacy_read_total, read_fallback_total,
           ecam_write_total, legacy_write_total, write_fallback_total,
    output ready
  );

endinterface

>>> rtl/pci_config_address_router_top.sv
// ----------------------------------------------------------------------------
// pci_config_address_router_top
// Pipeline: input register, then result register after the region match and
// one 64-bit add.
// Throughput: one transaction per cycle, limited only by result backpressure.
// Reset (rst_n low, synchronous): pipeline empty, region registers and all
// six access counters cleared to zero.
// ----------------------------------------------------------------------------
module pci_config_address_router_top import pcar_pkg::*; #(
  parameter int REGION_SLOTS = REGION_SLOTS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  pcar_req_if.sink               in_req,
  pcar_rsp_if.source             out_rsp,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int NUM_REGIONS = (REGION_SLOTS < CFG_REGIONS) ? REGION_SLOTS : CFG_REGIONS;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BUS_W-1:0]  bus_number;
    logic [DEV_W-1:0]  device_number;
    logic [FN_W-1:0]   function_number;
    logic [OFF_W-1:0]  register_offset;
    logic [DATA_W-1:0] write_data;
  } req_t;

  typedef struct packed {
    logic [CNT_W-1:0] ecam_reads;
    logic [CNT_W-1:0] legacy_reads;
    logic [CNT_W-1:0] fallback_reads;
    logic [CNT_W-1:0] ecam_writes;
    logic [CNT_W-1:0] legacy_writes;
    logic [CNT_W-1:0] fallback_writes;
  } counters_t;

  typedef struct packed {
    logic              via_ecam;
    logic [ADDR_W-1:0] target_address;
    logic              fell_back;
    logic [DATA_W-1:0] store_data;
    counters_t         totals;
  } rsp_t;

  // configuration registers
  logic [REGION_COUNT_W-1:0] region_count_r;
  logic [ADDR_W-1:0]         base_r  [NUM_REGIONS];
  logic [BUS_W-1:0]          first_r [NUM_REGIONS];
  logic [BUS_W-1:0]          last_r  [NUM_REGIONS];

  // pipeline
  logic      s1_valid_r;
  req_t      s1_req_r;
  logic      out_valid_r;
  rsp_t      out_rsp_r;
  counters_t cnt_r;
  counters_t cnt_nxt;
  rsp_t      rsp_nxt;
  logic      advance;

  // match logic
  logic                     ecam_ok;
  logic [NUM_REGIONS-1:0]   region_hit;
  logic                     hit;
  logic [ADDR_W-1:0]        sel_base;
  logic [BUS_W-1:0]         sel_first;
  logic [BUS_W-1:0]         bus_delta;
  logic [ECAM_OFFSET_W-1:0] ecam_offset;
  logic [ADDR_W-1:0]        ecam_addr;
  logic [31:0]              legacy_word;
  logic                     fell;

  assign advance      = s1_valid_r && (!out_valid_r || out_rsp.ready);
  assign in_req.ready = !s1_valid_r || advance;

  // region_count plus per-region descriptors
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_count_r <= '0;
    end else if (cfg_we && cfg_index == CFG_REGION_COUNT) begin
      region_count_r <= cfg_wdata[REGION_COUNT_W-1:0];
    end
  end

  for (genvar g = 0; g < NUM_REGIONS; g++) begin : g_region
    localparam logic [CFG_INDEX_W-1:0] IDX_BASE =
      CFG_INDEX_W'(int'(CFG_REGION0_BASE) + CFG_REGION_STRIDE * g);
    localparam logic [CFG_INDEX_W-1:0] IDX_FIRST =
      CFG_INDEX_W'(int'(CFG_REGION0_FIRST_BUS) + CFG_REGION_STRIDE * g);
    localparam logic [CFG_INDEX_W-1:0] IDX_LAST =
      CFG_INDEX_W'(int'(CFG_REGION0_LAST_BUS) + CFG_REGION_STRIDE * g);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        base_r[g]  <= '0;
        first_r[g] <= '0;
        last_r[g]  <= '0;
      end else if (cfg_we) begin
        if (cfg_index == IDX_BASE) begin
          base_r[g] <= cfg_wdata;
        end
        if (cfg_index == IDX_FIRST) begin
          first_r[g] <= cfg_wdata[BUS_W-1:0];
        end
        if (cfg_index == IDX_LAST) begin
          last_r[g] <= cfg_wdata[BUS_W-1:0];
        end
      end
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_req.ready) begin
      s1_valid_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      s1_req_r <= '{kind:            in_req.kind,
                    bus_number:      in_req.bus_number,
                    device_number:   in_req.device_number,
                    function_number: in_req.function_number,
                    register_offset: in_req.register_offset,
                    write_data:      in_req.write_data};
    end
  end

  // ecam eligibility and region search, first matching region wins
  always_comb begin
    ecam_ok = (s1_req_r.device_number < DEV_W'(ECAM_DEV_LIMIT)) &&
              (s1_req_r.function_number < FN_W'(ECAM_FN_LIMIT)) &&
              (s1_req_r.register_offset[1:0] == 2'b00) &&
              (s1_req_r.register_offset < OFF_W'(ECAM_OFF_LIMIT));
    for (int i = 0; i < NUM_REGIONS; i++) begin
      region_hit[i] = ecam_ok &&
                      (region_count_r > REGION_COUNT_W'(i)) &&
                      (s1_req_r.bus_number >= first_r[i]) &&
                      (s1_req_r.bus_number <= last_r[i]);
    end
    hit       = |region_hit;
    sel_base  = '0;
    sel_first = '0;
    for (int i = NUM_REGIONS - 1; i >= 0; i--) begin
      if (region_hit[i]) begin
        sel_base  = base_r[i];
        sel_first = first_r[i];
      end
    end
  end

  always_comb begin
    bus_delta   = s1_req_r.bus_number - sel_first;
    ecam_offset = {bus_delta,
                   s1_req_r.device_number[ECAM_DEV_W-1:0],
                   s1_req_r.function_number[ECAM_FN_W-1:0],
                   s1_req_r.register_offset[ECAM_OFF_W-1:0]};
    ecam_addr   = sel_base + ADDR_W'(ecam_offset);
    legacy_word = LEGACY_ENABLE |
                  (32'(s1_req_r.bus_number) << LEGACY_BUS_SH) |
                  (32'(s1_req_r.device_number) << LEGACY_DEV_SH) |
                  (32'(s1_req_r.function_number) << LEGACY_FN_SH) |
                  32'(s1_req_r.register_offset[7:0] & LEGACY_REG_MASK);
    fell        = !hit && (region_count_r != '0);
  end

  // counter update for the transaction in the input register
  always_comb begin
    cnt_nxt = cnt_r;
    if (s1_req_r.kind == KIND_WRITE) begin
      if (hit) begin
        cnt_nxt.ecam_writes = cnt_r.ecam_writes + 1'b1;
      end else begin
        cnt_nxt.legacy_writes = cnt_r.legacy_writes + 1'b1;
        if (fell) begin
          cnt_nxt.fallback_writes = cnt_r.fallback_writes + 1'b1;
        end
      end
    end else begin
      if (hit) begin
        cnt_nxt.ecam_reads = cnt_r.ecam_reads + 1'b1;
      end else begin
        cnt_nxt.legacy_reads = cnt_r.legacy_reads + 1'b1;
        if (fell) begin
          cnt_nxt.fallback_reads = cnt_r.fallback_reads + 1'b1;
        end
      end
    end

    rsp_nxt.via_ecam       = hit;
    rsp_nxt.target_address = hit ? ecam_addr : ADDR_W'(legacy_word);
    rsp_nxt.fell_back      = fell;
    rsp_nxt.store_data     = (s1_req_r.kind == KIND_WRITE) ? s1_req_r.write_data : '0;
    rsp_nxt.totals         = cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (advance) begin
      cnt_r <= cnt_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_rsp_r <= rsp_nxt;
    end
  end

  assign out_rsp.valid                = out_valid_r;
  assign out_rsp.via_ecam             = out_rsp_r.via_ecam;
  assign out_rsp.target_address       = out_rsp_r.target_address;
  assign out_rsp.fell_back            = out_rsp_r.fell_back;
  assign out_rsp.store_data           = out_rsp_r.store_data;
  assign out_rsp.ecam_read_total      = out_rsp_r.totals.ecam_reads;
  assign out_rsp.legacy_read_total    = out_rsp_r.totals.legacy_reads;
  assign out_rsp.read_fallback_total  = out_rsp_r.totals.fallback_reads;
  assign out_rsp.ecam_write_total     = out_rsp_r.totals.ecam_writes;
  assign out_rsp.legacy_write_total   = out_rsp_r.totals.legacy_writes;
  assign out_rsp.write_fallback_total = out_rsp_r.totals.fallback_writes;

  // ecam hit and fallback are exclusive
  a_ecam_not_fallback: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_rsp_r.via_ecam && out_rsp_r.fell_back))
    else $error("result marked both ecam and fallback");

  // legacy results carry only the 32-bit port word with the enable bit set
  a_legacy_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_rsp_r.via_ecam) |->
      (out_rsp_r.target_address[ADDR_W-1:32] == '0 && out_rsp_r.target_address[31]))
    else $error("legacy address word malformed");

  // an ecam write bumps exactly its own counter
  a_ecam_write_count: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && hit && s1_req_r.kind == KIND_WRITE) |=>
      (cnt_r.ecam_writes == $past(cnt_r.ecam_writes) + 1'b1 &&
       cnt_r.legacy_writes == $past(cnt_r.legacy_writes)))
    else $error("ecam write counter did not advance");

  // request side stalls only when both stages are full and the result is held
  a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
    !in_req.ready |-> (s1_valid_r && out_valid_r && !out_rsp.ready))
    else $error("request stalled without backpressure");

  // the result register never drops a transaction that was not taken
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_rsp.ready) |=> (out_valid_r && $stable(out_rsp_r)))
    else $error("pending result lost or changed");

endmodule

>>> tb/tb_pci_config_address_router_top.sv
// ----------------------------------------------------------------------------
// tb_pci_config_address_router_top
// Self-checking bench for the config address router. Requests go in through
// the request channel in random bursts while the result channel stalls on a
// pattern of its own. Every accepted transaction is translated by a local
// ECAM/legacy route predictor, and each result is compared field by field
// against the oldest predicted route. Region setups are swept between phases.
// ----------------------------------------------------------------------------
module tb_pci_config_address_router_top;
  import pcar_pkg::*;

  localparam int REGION_SLOTS    = REGION_SLOTS_DEFAULT;
  localparam int ECAM_BUS_SH     = ECAM_OFF_W + ECAM_FN_W + ECAM_DEV_W;
  localparam int ECAM_DEV_SH     = ECAM_OFF_W + ECAM_FN_W;
  localparam int ECAM_FN_SH      = ECAM_OFF_W;
  localparam int PIPE_SLACK      = 4;
  localparam int MAX_GAP         = 12;
  localparam int MAX_BURST       = 24;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int STALL_LIMIT     = 2000;
  localparam int RANDOM_PHASES   = 8;
  localparam int PHASE_ITEMS     = 100;
  localparam int MAX_REPORTS     = 10;

  // index with no register behind it, writes there must be dropped
  localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_SPARE = 3'd7;

  typedef struct packed {
    req_kind_e         kind;
    logic [BUS_W-1:0]  bus;
    logic [DEV_W-1:0]  dev;
    logic [FN_W-1:0]   fn;
    logic [OFF_W-1:0]  offset;
    logic [DATA_W-1:0] data;
  } route_req_t;

  typedef struct packed {
    logic              via_ecam;
    logic [ADDR_W-1:0] target_address;
    logic              fell_back;
    logic [DATA_W-1:0] store_data;
    logic [CNT_W-1:0]  ecam_reads;
    logic [CNT_W-1:0]  legacy_reads;
    logic [CNT_W-1:0]  fallback_reads;
    logic [CNT_W-1:0]  ecam_writes;
    logic [CNT_W-1:0]  legacy_writes;
    logic [CNT_W-1:0]  fallback_writes;
  } route_rsp_t;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;

  pcar_req_if req_if ();
  pcar_rsp_if rsp_if ();

  pci_config_address_router_top #(
    .REGION_SLOTS(REGION_SLOTS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (req_if),
    .out_rsp  (rsp_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // local copy of the region registers and access counters
  logic [REGION_COUNT_W-1:0] region_count_m;
  logic [ADDR_W-1:0]         region_base_m  [CFG_REGIONS];
  logic [BUS_W-1:0]          region_first_m [CFG_REGIONS];
  logic [BUS_W-1:0]          region_last_m  [CFG_REGIONS];
  logic [CNT_W-1:0]          ecam_reads_m, legacy_reads_m, fallback_reads_m;
  logic [CNT_W-1:0]          ecam_writes_m, legacy_writes_m, fallback_writes_m;

  route_rsp_t  expected_routes[$];
  int unsigned failures;
  int unsigned reports;
  int unsigned burst_left;
  int unsigned idle_cycles;
  bit          hold_off_pending;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic route_rsp_t route_request(input route_req_t r);
    route_rsp_t  o;
    int unsigned searched;
    int          i;
    logic        hit;
    logic [31:0] port_word;
    o        = '0;
    hit      = 1'b0;
    searched = 32'(region_count_m);
    if (searched > REGION_SLOTS) searched = REGION_SLOTS;
    if (searched > CFG_REGIONS) searched = CFG_REGIONS;
    if (r.dev < ECAM_DEV_LIMIT && r.fn < ECAM_FN_LIMIT && r.offset[1:0] == 2'b00 &&
        r.offset < ECAM_OFF_LIMIT) begin
      for (i = 0; i < CFG_REGIONS; i++) begin
        // first region covering the bus wins, empty ranges never match
        if (!hit && i < searched && r.bus >= region_first_m[i] &&
            r.bus <= region_last_m[i]) begin
          hit = 1'b1;
          o.target_address = region_base_m[i]
                           + (ADDR_W'(r.bus - region_first_m[i]) << ECAM_BUS_SH)
                           + (ADDR_W'(r.dev) << ECAM_DEV_SH)
                           + (ADDR_W'(r.fn) << ECAM_FN_SH)
                           + ADDR_W'(r.offset);
        end
      end
    end
    if (!hit) begin
      port_word = LEGACY_ENABLE | (32'(r.bus) << LEGACY_BUS_SH) |
                  (32'(r.dev) << LEGACY_DEV_SH) | (32'(r.fn) << LEGACY_FN_SH) |
                  {24'd0, r.offset[7:0] & LEGACY_REG_MASK};
      o.target_address = {32'd0, port_word};
      o.fell_back      = (region_count_m != '0);
    end
    o.via_ecam = hit;
    if (r.kind == KIND_WRITE) begin
      o.store_data = r.data;
      if (hit) begin
        ecam_writes_m++;
      end else begin
        if (o.fell_back) fallback_writes_m++;
        legacy_writes_m++;
      end
    end else begin
      if (hit) begin
        ecam_reads_m++;
      end else begin
        if (o.fell_back) fallback_reads_m++;
        legacy_reads_m++;
      end
    end
    o.ecam_reads      = ecam_reads_m;
    o.legacy_reads    = legacy_reads_m;
    o.fallback_reads  = fallback_reads_m;
    o.ecam_writes     = ecam_writes_m;
    o.legacy_writes   = legacy_writes_m;
    o.fallback_writes = fallback_writes_m;
    return o;
  endfunction

  function automatic route_req_t cfg_request(input req_kind_e kind, input int unsigned bus,
                                             input int unsigned dev, input int unsigned fn,
                                             input int unsigned offset,
                                             input logic [DATA_W-1:0] data);
    route_req_t r;
    r.kind   = kind;
    r.bus    = BUS_W'(bus);
    r.dev    = DEV_W'(dev);
    r.fn     = FN_W'(fn);
    r.offset = OFF_W'(offset);
    r.data   = data;
    return r;
  endfunction

  // mostly well-formed requests aimed at the configured bus ranges,
  // the rest broken in one field or pure noise
  function automatic route_req_t random_request();
    route_req_t  r;
    int unsigned pick;
    int unsigned slot;
    pick   = $urandom_range(0, 99);
    r.kind = req_kind_e'($urandom_range(0, 1));
    r.data = $urandom;
    r.bus  = BUS_W'($urandom_range(0, 255));
    if (pick < 15) begin
      r.dev    = DEV_W'($urandom_range(0, 255));
      r.fn     = FN_W'($urandom_range(0, 255));
      r.offset = OFF_W'($urandom_range(0, 8191));
      return r;
    end
    r.dev    = DEV_W'($urandom_range(0, ECAM_DEV_LIMIT - 1));
    r.fn     = FN_W'($urandom_range(0, ECAM_FN_LIMIT - 1));
    r.offset = OFF_W'(4 * $urandom_range(0, ECAM_OFF_LIMIT / 4 - 1));
    slot     = $urandom_range(0, CFG_REGIONS - 1);
    if ($urandom_range(0, 3) != 0 && region_first_m[slot] <= region_last_m[slot]) begin
      case ($urandom_range(0, 5))
        0:       r.bus = region_first_m[slot];
        1:       r.bus = region_last_m[slot];
        default: r.bus = BUS_W'($urandom_range(region_first_m[slot], region_last_m[slot]));
      endcase
    end
    if (pick >= 80) begin
      case ($urandom_range(0, 3))
        0: r.dev = DEV_W'($urandom_range(ECAM_DEV_LIMIT, 255));
        1: r.fn = FN_W'($urandom_range(ECAM_FN_LIMIT, 255));
        2: r.offset[1:0] = 2'($urandom_range(1, 3));
        default: r.offset[12] = 1'b1;
      endcase
    end
    return r;
  endfunction

  task automatic send_request(input route_req_t r);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, MAX_BURST);
      if ($urandom_range(0, 2) == 0) begin
        gap = $urandom_range(1, MAX_GAP);
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req_if.valid           <= 1'b1;
    req_if.kind            <= r.kind;
    req_if.bus_number      <= r.bus;
    req_if.device_number   <= r.dev;
    req_if.function_number <= r.fn;
    req_if.register_offset <= r.offset;
    req_if.write_data      <= r.data;
    do @(posedge clk); while (!req_if.ready);
    expected_routes.push_back(route_request(r));
  endtask

  // block is idle once every predicted route has come back
  task automatic drain();
    req_if.valid <= 1'b0;
    burst_left = 0;
    while (expected_routes.size() != 0) @(posedge clk);
    repeat (PIPE_SLACK) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      CFG_REGION_COUNT:      region_count_m    = value[REGION_COUNT_W-1:0];
      CFG_REGION0_BASE:      region_base_m[0]  = value;
      CFG_REGION0_FIRST_BUS: region_first_m[0] = value[BUS_W-1:0];
      CFG_REGION0_LAST_BUS:  region_last_m[0]  = value[BUS_W-1:0];
      CFG_REGION1_BASE:      region_base_m[1]  = value;
      CFG_REGION1_FIRST_BUS: region_first_m[1] = value[BUS_W-1:0];
      CFG_REGION1_LAST_BUS:  region_last_m[1]  = value[BUS_W-1:0];
      default: ;
    endcase
  endtask

  // narrow registers get junk in the unused upper bits
  task automatic apply_regions(input logic [1:0] count, input logic [63:0] base0,
                               input logic [7:0] first0, input logic [7:0] last0,
                               input logic [63:0] base1, input logic [7:0] first1,
                               input logic [7:0] last1);
    write_register(CFG_REGION_COUNT, {$urandom, 30'($urandom), count});
    write_register(CFG_REGION0_BASE, base0);
    write_register(CFG_REGION0_FIRST_BUS, {$urandom, 24'($urandom), first0});
    write_register(CFG_REGION0_LAST_BUS, {$urandom, 24'($urandom), last0});
    write_register(CFG_REGION1_BASE, base1);
    write_register(CFG_REGION1_FIRST_BUS, {$urandom, 24'($urandom), first1});
    write_register(CFG_REGION1_LAST_BUS, {$urandom, 24'($urandom), last1});
    write_register(CFG_INDEX_SPARE, {$urandom, $urandom});
    cfg_we <= 1'b0;
  endtask

  task automatic randomize_regions(input int unsigned flavor);
    logic [1:0]  count;
    logic [63:0] base0, base1;
    logic [7:0]  first0, last0, first1, last1, swap;
    count  = 2'($urandom_range(1, 3));
    base0  = {$urandom, $urandom};
    base1  = {$urandom, $urandom};
    first0 = 8'($urandom_range(0, 255));
    last0  = 8'($urandom_range(0, 255));
    first1 = 8'($urandom_range(0, 255));
    last1  = 8'($urandom_range(0, 255));
    if (first0 > last0) begin swap = first0; first0 = last0; last0 = swap; end
    if (first1 > last1) begin swap = first1; first1 = last1; last1 = swap; end
    case (flavor)
      0: count = 2'd0;
      1: begin
        count  = 2'd1;
        base0  = '1;
        first0 = 8'h00;
        last0  = 8'hff;
      end
      2: begin
        count  = 2'd2;
        base0  = '0;
        first1 = 8'h00;
        last1  = 8'hff;
      end
      3: count = 2'd3;
      4: begin
        count  = 2'd2;
        first0 = 8'hc0;
        last0  = 8'h3f;
      end
      default: ;
    endcase
    apply_regions(count, base0, first0, last0, base1, first1, last1);
  endtask

  // regions are all clear after reset, so everything takes the legacy port
  task automatic test_reset_defaults();
    send_request(cfg_request(KIND_READ, 0, 0, 0, 0, 32'hffff_ffff));
    send_request(cfg_request(KIND_WRITE, 255, 255, 255, 8191, 32'hffff_ffff));
    send_request(cfg_request(KIND_WRITE, 8'h12, 3, 1, 12'h040, 32'h0000_0000));
    drain();
  endtask

  // region one is programmed but must not be searched with a count of one
  task automatic test_single_region();
    apply_regions(2'd1, 64'h0000_00e0_0000_0000, 8'h10, 8'h1f,
                  64'hffff_ffff_ffff_ffff, 8'h00, 8'hff);
    send_request(cfg_request(KIND_READ, 8'h10, 0, 0, 0, 32'h1234_5678));
    send_request(cfg_request(KIND_WRITE, 8'h1f, 31, 7, 4092, 32'hdead_beef));
    send_request(cfg_request(KIND_READ, 8'h0f, 1, 2, 8, 32'h0));
    send_request(cfg_request(KIND_READ, 8'h20, 1, 2, 8, 32'h0));
    send_request(cfg_request(KIND_WRITE, 8'h15, 32, 0, 4, 32'h5555_aaaa));
    send_request(cfg_request(KIND_READ, 8'h15, 4, 8, 4, 32'h0));
    send_request(cfg_request(KIND_READ, 8'h15, 4, 1, 4096, 32'h0));
    send_request(cfg_request(KIND_WRITE, 8'h15, 4, 1, 12'h102, 32'haaaa_5555));
    send_request(cfg_request(KIND_READ, 8'h15, 4, 1, 8188, 32'h0));
    drain();
  endtask

  // overlapping regions, the lower slot wins, and a base that wraps past 2^64
  task automatic test_two_regions();
    apply_regions(2'd2, 64'hffff_ffff_fff0_0000, 8'h00, 8'h7f,
                  64'h0000_0010_0000_0000, 8'h40, 8'hff);
    send_request(cfg_request(KIND_READ, 8'h7f, 31, 7, 4092, 32'h0));
    send_request(cfg_request(KIND_WRITE, 8'h40, 5, 3, 16, 32'h0bad_f00d));
    send_request(cfg_request(KIND_READ, 8'h80, 0, 0, 0, 32'h0));
    send_request(cfg_request(KIND_WRITE, 8'hff, 31, 7, 4092, 32'h0));
    drain();
  endtask

  // count above the slot number, an empty region, then no usable region at all
  task automatic test_region_edge_cases();
    apply_regions(2'd3, 64'h0000_1000_0000_0000, 8'h90, 8'h8f,
                  64'h0, 8'h00, 8'hff);
    send_request(cfg_request(KIND_READ, 8'h90, 2, 1, 32, 32'h0));
    send_request(cfg_request(KIND_WRITE, 8'h00, 0, 0, 0, 32'h8000_0001));
    send_request(cfg_request(KIND_READ, 8'h33, 200, 1, 32, 32'h0));
    drain();
    apply_regions(2'd2, 64'h1, 8'hff, 8'h00, 64'h2, 8'h80, 8'h7f);
    send_request(cfg_request(KIND_READ, 8'hff, 0, 0, 0, 32'h0));
    drain();
  endtask

  task automatic test_random_traffic();
    int p;
    int n;
    for (p = 0; p < RANDOM_PHASES; p++) begin
      randomize_regions((p < 6) ? p : $urandom_range(0, 6));
      for (n = 0; n < PHASE_ITEMS; n++) send_request(random_request());
      drain();
    end
  endtask

  // result side holds off long enough for the pipeline to back up into the input
  task automatic test_backpressure();
    int n;
    randomize_regions(2);
    hold_off_pending = 1'b1;
    for (n = 0; n < 60; n++) send_request(random_request());
    drain();
  endtask

  task automatic finish_run();
    drain();
    if (expected_routes.size() != 0) failures += expected_routes.size();
    if (failures == 0) begin
      $display("pci_config_address_router_top verification clean");
    end else begin
      $display("pci_config_address_router_top verification failed");
    end
    $finish;
  endtask

  // result receiver: ready pattern switches between random stall modes
  initial begin : result_receiver
    int unsigned stall_mode;
    int unsigned span_left;
    int          k;
    logic [7:0]  pattern;
    rsp_if.ready = 1'b0;
    span_left    = 0;
    stall_mode   = 0;
    pattern      = 8'b1011_0010;
    forever begin
      @(posedge clk);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        rsp_if.ready <= 1'b0;
        for (k = 0; k < HOLD_OFF_CYCLES; k++) @(posedge clk);
      end
      if (span_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        span_left  = $urandom_range(8, 64);
      end
      span_left--;
      pattern = {pattern[6:0], pattern[7]};
      case (stall_mode)
        0:       rsp_if.ready <= 1'b1;
        1:       rsp_if.ready <= 1'($urandom_range(0, 1));
        2:       rsp_if.ready <= ($urandom_range(0, 3) == 0);
        default: rsp_if.ready <= pattern[0];
      endcase
    end
  end

  always @(posedge clk) begin : result_check
    route_rsp_t got;
    route_rsp_t want;
    string      diff;
    if (rst_n && rsp_if.valid && rsp_if.ready) begin
      got.via_ecam        = rsp_if.via_ecam;
      got.target_address  = rsp_if.target_address;
      got.fell_back       = rsp_if.fell_back;
      got.store_data      = rsp_if.store_data;
      got.ecam_reads      = rsp_if.ecam_read_total;
      got.legacy_reads    = rsp_if.legacy_read_total;
      got.fallback_reads  = rsp_if.read_fallback_total;
      got.ecam_writes     = rsp_if.ecam_write_total;
      got.legacy_writes   = rsp_if.legacy_write_total;
      got.fallback_writes = rsp_if.write_fallback_total;
      if (expected_routes.size() == 0) begin
        failures++;
        reports++;
        if (reports <= MAX_REPORTS)
          $display("unexpected result transaction: addr=%h ecam=%b", got.target_address,
                   got.via_ecam);
      end else begin
        want = expected_routes.pop_front();
        diff = "";
        if (got.via_ecam !== want.via_ecam) diff = {diff, " via_ecam"};
        if (got.target_address !== want.target_address) diff = {diff, " target_address"};
        if (got.fell_back !== want.fell_back) diff = {diff, " fell_back"};
        if (got.store_data !== want.store_data) diff = {diff, " store_data"};
        if (got.ecam_reads !== want.ecam_reads) diff = {diff, " ecam_read_total"};
        if (got.legacy_reads !== want.legacy_reads) diff = {diff, " legacy_read_total"};
        if (got.fallback_reads !== want.fallback_reads) diff = {diff, " read_fallback_total"};
        if (got.ecam_writes !== want.ecam_writes) diff = {diff, " ecam_write_total"};
        if (got.legacy_writes !== want.legacy_writes) diff = {diff, " legacy_write_total"};
        if (got.fallback_writes !== want.fallback_writes)
          diff = {diff, " write_fallback_total"};
        if (diff != "") begin
          failures++;
          reports++;
          if (reports <= MAX_REPORTS) begin
            $display("mismatch at %0t on%s", $realtime, diff);
            $display("  expected ecam=%b addr=%h fb=%b data=%h cnt=%h %h %h %h %h %h",
                     want.via_ecam, want.target_address, want.fell_back, want.store_data,
                     want.ecam_reads, want.legacy_reads, want.fallback_reads,
                     want.ecam_writes, want.legacy_writes, want.fallback_writes);
            $display("  actual   ecam=%b addr=%h fb=%b data=%h cnt=%h %h %h %h %h %h",
                     got.via_ecam, got.target_address, got.fell_back, got.store_data,
                     got.ecam_reads, got.legacy_reads, got.fallback_reads,
                     got.ecam_writes, got.legacy_writes, got.fallback_writes);
          end
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || cfg_we) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
      $display("pci_config_address_router_top verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n                  = 1'b0;
    cfg_we                 = 1'b0;
    cfg_index              = CFG_REGION_COUNT;
    cfg_wdata              = '0;
    req_if.valid           = 1'b0;
    req_if.kind            = KIND_READ;
    req_if.bus_number      = '0;
    req_if.device_number   = '0;
    req_if.function_number = '0;
    req_if.register_offset = '0;
    req_if.write_data      = '0;
    idle_cycles            = 0;
    failures               = 0;
    reports                = 0;
    burst_left             = 0;
    hold_off_pending       = 1'b0;
    region_count_m         = '0;
    for (int i = 0; i < CFG_REGIONS; i++) begin
      region_base_m[i]  = '0;
      region_first_m[i] = '0;
      region_last_m[i]  = '0;
    end
    ecam_reads_m      = '0;
    legacy_reads_m    = '0;
    fallback_reads_m  = '0;
    ecam_writes_m     = '0;
    legacy_writes_m   = '0;
    fallback_writes_m = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_single_region();
    test_two_regions();
    test_region_edge_cases();
    test_random_traffic();
    test_backpressure();
    finish_run();
  end

endmodule
